/* hdl/gaussian_blur_replicate_border_assert.svh */
// Assertion macros shared by the blur block's RTL files.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef GAUSSIAN_BLUR_REPLICATE_BORDER_ASSERT_SVH
`define GAUSSIAN_BLUR_REPLICATE_BORDER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define GBR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbr assertion failed");
// next-cycle implication
`define GBR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbr assertion failed");
`else
`define GBR_ASSERT_IMPL(lbl, ante, cons)
`define GBR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hdl/gbr_pkg.sv */
// Shared types and constants of the Gaussian blur block.
// No dependencies.
`default_nettype none
package gbr_pkg;
  localparam int PIX_W     = 8;
  localparam int POS_W     = 10;
  localparam int TAP_W     = 17;
  localparam int TAP_ONE   = 65536;
  localparam int NUM_TAPS  = 4;
  localparam int PROD_W    = 25;
  localparam int COL_W     = 27;
  localparam int COLP_W    = 44;
  localparam int ACC_W     = 47;
  localparam int FRAC_W    = 32;
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 5;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAP0   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP1   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TAP2   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TAP3   = 3'd6;

  // one window read in flight through the filter pipeline
  typedef struct packed {
    logic             valid;
    logic             first_row;
    logic             last_row;
    logic             first_col;
    logic             last_all;
    logic [TAP_W-1:0] wy;
    logic [TAP_W-1:0] wx;
  } tag_t;

  // position of the pixel being computed
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } job_t;

  // filter status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } stat_t;
endpackage
`default_nettype wire

/* hdl/gbr_in_if.sv */
// Input channel of the blur block: valid/ready plus one pixel beat and its action bit.
// Depends on gbr_pkg.
`default_nettype none
interface gbr_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [gbr_pkg::PIX_W-1:0]  pixel_in;
  modport source (output valid, action, pixel_in, input ready);
  modport sink   (input valid, action, pixel_in, output ready);
endinterface
`default_nettype wire

/* hdl/gbr_out_if.sv */
// Result channel of the blur block: valid/ready plus one output pixel beat.
// Depends on gbr_pkg.
`default_nettype none
interface gbr_out_if;
  logic                       valid;
  logic                       ready;
  logic [gbr_pkg::PIX_W-1:0]  pixel_out;
  logic [gbr_pkg::POS_W-1:0]  out_row;
  logic [gbr_pkg::POS_W-1:0]  out_col;
  logic                       frame_last;
  modport source (output valid, pixel_out, out_row, out_col, frame_last, input ready);
  modport sink   (input valid, pixel_out, out_row, out_col, frame_last, output ready);
endinterface
`default_nettype wire

/* hdl/gbr_cfg.sv */
// APB-style register file: radius, frame size and the four 1-D taps.
// Depends on gbr_pkg; outputs already saturated values.
`default_nettype none
module gbr_cfg #(
  parameter int MAX_RADIUS = 3,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int WW = $clog2(MAX_WIDTH) + 1,
  localparam int HW = $clog2(MAX_HEIGHT) + 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [gbr_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [gbr_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic      [gbr_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                              cfg_pready,
  output logic      [1:0]                   rad_eff,
  output logic      [WW-1:0]                wid_eff,
  output logic      [HW-1:0]                hgt_eff,
  output logic      [gbr_pkg::TAP_W-1:0]    taps [gbr_pkg::NUM_TAPS],
  output logic                              restart
);
  logic [1:0]                  rad_r;
  logic [10:0]                 wid_r;
  logic [10:0]                 hgt_r;
  logic [gbr_pkg::TAP_W-1:0]   tap_r [gbr_pkg::NUM_TAPS];
  logic [gbr_pkg::CFG_IDX_W-1:0] idx;
  logic                        wr;

  assign idx        = cfg_paddr[gbr_pkg::CFG_AW-1:2];
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign restart    = wr && (idx inside {gbr_pkg::REG_RADIUS, gbr_pkg::REG_WIDTH,
                                         gbr_pkg::REG_HEIGHT});

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r    <= 2'd0;
      wid_r    <= 11'd1024;
      hgt_r    <= 11'd1024;
      tap_r[0] <= gbr_pkg::TAP_W'(gbr_pkg::TAP_ONE);
      tap_r[1] <= '0;
      tap_r[2] <= '0;
      tap_r[3] <= '0;
    end else if (wr) begin
      case (idx)
        gbr_pkg::REG_RADIUS: rad_r    <= cfg_pwdata[1:0];
        gbr_pkg::REG_WIDTH:  wid_r    <= cfg_pwdata[10:0];
        gbr_pkg::REG_HEIGHT: hgt_r    <= cfg_pwdata[10:0];
        gbr_pkg::REG_TAP0:   tap_r[0] <= cfg_pwdata[gbr_pkg::TAP_W-1:0];
        gbr_pkg::REG_TAP1:   tap_r[1] <= cfg_pwdata[gbr_pkg::TAP_W-1:0];
        gbr_pkg::REG_TAP2:   tap_r[2] <= cfg_pwdata[gbr_pkg::TAP_W-1:0];
        gbr_pkg::REG_TAP3:   tap_r[3] <= cfg_pwdata[gbr_pkg::TAP_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      gbr_pkg::REG_RADIUS: cfg_prdata = gbr_pkg::CFG_DW'(rad_r);
      gbr_pkg::REG_WIDTH:  cfg_prdata = gbr_pkg::CFG_DW'(wid_r);
      gbr_pkg::REG_HEIGHT: cfg_prdata = gbr_pkg::CFG_DW'(hgt_r);
      gbr_pkg::REG_TAP0:   cfg_prdata = gbr_pkg::CFG_DW'(tap_r[0]);
      gbr_pkg::REG_TAP1:   cfg_prdata = gbr_pkg::CFG_DW'(tap_r[1]);
      gbr_pkg::REG_TAP2:   cfg_prdata = gbr_pkg::CFG_DW'(tap_r[2]);
      gbr_pkg::REG_TAP3:   cfg_prdata = gbr_pkg::CFG_DW'(tap_r[3]);
      default:             cfg_prdata = '0;
    endcase
  end

  // saturated working values
  always_comb begin
    rad_eff = (32'(rad_r) > MAX_RADIUS) ? 2'(MAX_RADIUS) : rad_r;
    if (wid_r == '0)                wid_eff = WW'(1);
    else if (32'(wid_r) > MAX_WIDTH) wid_eff = WW'(MAX_WIDTH);
    else                            wid_eff = WW'(wid_r);
    if (hgt_r == '0)                 hgt_eff = HW'(1);
    else if (32'(hgt_r) > MAX_HEIGHT) hgt_eff = HW'(MAX_HEIGHT);
    else                             hgt_eff = HW'(hgt_r);
    for (int i = 0; i < gbr_pkg::NUM_TAPS; i++) begin
      taps[i] = (32'(tap_r[i]) > gbr_pkg::TAP_ONE) ?
                gbr_pkg::TAP_W'(gbr_pkg::TAP_ONE) : tap_r[i];
    end
  end
endmodule
`default_nettype wire

/* hdl/gbr_line_store.sv */
// Circular line store: one write port, one read port with registered data.
// Depends on nothing; depth set by the instantiating module.
`default_nettype none
module gbr_line_store #(
  parameter int DEPTH = 7168,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hdl/gbr_ctrl.sv */
// Sequencer: frame counters, window readiness, window address generation.
// Depends on gbr_pkg, gbr_in_if and the assertion header.
`default_nettype none
`include "gaussian_blur_replicate_border_assert.svh"
module gbr_ctrl #(
  parameter int MAX_RADIUS = 3,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int CW    = $clog2(MAX_WIDTH),
  localparam int RW    = $clog2(MAX_HEIGHT),
  localparam int WW    = CW + 1,
  localparam int HW    = RW + 1,
  localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  gbr_in_if.sink                         in_if,
  input  wire logic [1:0]                rad,
  input  wire logic [WW-1:0]             wid,
  input  wire logic [HW-1:0]             hgt,
  input  wire logic [gbr_pkg::TAP_W-1:0] taps [gbr_pkg::NUM_TAPS],
  input  wire logic                      restart,
  input  wire gbr_pkg::stat_t            stat,
  output logic                           mem_we,
  output logic [AW-1:0]                  mem_waddr,
  output logic [7:0]                     mem_wdata,
  output logic [AW-1:0]                  mem_raddr,
  output gbr_pkg::tag_t                  tag_r,
  output gbr_pkg::job_t                  job_r
);
  localparam int SW = AW + 2;
  localparam logic signed [SW-1:0] DEPTH_S = SW'(DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_WAIT  = 4'b1000
  } state_t;

  state_t          state_r;
  logic [RW-1:0]   in_row_r, out_row_r, job_oy_r;
  logic [CW-1:0]   in_col_r, out_col_r, job_ox_r;
  logic            frame_rcvd_r;
  logic [AW-1:0]   wr_addr_r, obase_r, job_obase_r, addr_r;
  logic [2:0]      ix_r, iy_r;

  logic [HW-1:0]   nr_full, nr, hmax;
  logic [WW-1:0]   nc_full, nc, wmax;
  logic            win_ready, is_last, push;
  logic [AW:0]     obase_inc;
  logic [2:0]      two_r, ady, adx;
  logic signed [4:0]    dy_s, dx_s;
  logic signed [RW+1:0] sy;
  logic signed [CW+1:0] sx;
  logic [RW-1:0]   rr;
  logic [CW-1:0]   cc;
  logic signed [SW-1:0] delta_s, rowoff, s1, s2;

  assign in_if.ready = (state_r == ST_IDLE);
  assign push        = in_if.valid && !in_if.action && !frame_rcvd_r;
  assign mem_we      = (state_r == ST_IDLE) && push;
  assign mem_waddr   = wr_addr_r;
  assign mem_wdata   = in_if.pixel_in;
  assign mem_raddr   = addr_r;

  // is the whole window of the next output in the store
  always_comb begin
    hmax    = hgt - HW'(1);
    wmax    = wid - WW'(1);
    nr_full = {1'b0, out_row_r} + HW'(rad);
    nc_full = {1'b0, out_col_r} + WW'(rad);
    nr      = (nr_full > hmax) ? hmax : nr_full;
    nc      = (nc_full > wmax) ? wmax : nc_full;
    win_ready = frame_rcvd_r || (nr < {1'b0, in_row_r}) ||
                ((nr == {1'b0, in_row_r}) && (nc < {1'b0, in_col_r}));
    is_last   = ({1'b0, out_row_r} == hmax) && ({1'b0, out_col_r} == wmax);
    obase_inc = {1'b0, obase_r} + (AW+1)'(wid);
    if (obase_inc >= (AW+1)'(DEPTH)) obase_inc = obase_inc - (AW+1)'(DEPTH);
  end

  // window tap address: clamp the position, then rebase modulo the store depth
  always_comb begin
    two_r = {rad, 1'b0};
    dy_s  = $signed({2'b00, iy_r}) - $signed({3'b000, rad});
    dx_s  = $signed({2'b00, ix_r}) - $signed({3'b000, rad});
    ady   = (iy_r >= {1'b0, rad}) ? iy_r - {1'b0, rad} : {1'b0, rad} - iy_r;
    adx   = (ix_r >= {1'b0, rad}) ? ix_r - {1'b0, rad} : {1'b0, rad} - ix_r;
    sy    = $signed({2'b00, job_oy_r}) + (RW+2)'(dy_s);
    sx    = $signed({2'b00, job_ox_r}) + (CW+2)'(dx_s);
    if (sy < 0)                          rr = '0;
    else if (sy >= $signed({1'b0, hgt})) rr = RW'(hmax);
    else                                 rr = sy[RW-1:0];
    if (sx < 0)                          cc = '0;
    else if (sx >= $signed({1'b0, wid})) cc = CW'(wmax);
    else                                 cc = sx[CW-1:0];
    delta_s = SW'($signed({1'b0, rr})) - SW'($signed({1'b0, job_oy_r}));
    rowoff  = delta_s * $signed(SW'({1'b0, wid}));
    s1 = $signed(SW'({1'b0, job_obase_r})) + rowoff;
    if (s1 < 0)             s1 = s1 + DEPTH_S;
    else if (s1 >= DEPTH_S) s1 = s1 - DEPTH_S;
    s2 = s1 + $signed(SW'({1'b0, cc}));
    if (s2 >= DEPTH_S) s2 = s2 - DEPTH_S;
  end

  // sequencer; the user must write geometry only while nothing is in flight, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      in_row_r     <= '0;
      in_col_r     <= '0;
      out_row_r    <= '0;
      out_col_r    <= '0;
      frame_rcvd_r <= 1'b0;
      wr_addr_r    <= '0;
      obase_r      <= '0;
      ix_r         <= '0;
      iy_r         <= '0;
      tag_r        <= '0;
    end else if (restart) begin
      in_row_r     <= '0;
      in_col_r     <= '0;
      out_row_r    <= '0;
      out_col_r    <= '0;
      frame_rcvd_r <= 1'b0;
      wr_addr_r    <= '0;
      obase_r      <= '0;
      tag_r.valid  <= 1'b0;
    end else begin
      tag_r.valid <= (state_r == ST_RUN);
      case (state_r)
        ST_IDLE: begin
          if (in_if.valid) begin
            if (push) begin
              if ({1'b0, wr_addr_r} + 1'b1 == (AW+1)'(DEPTH)) wr_addr_r <= '0;
              else wr_addr_r <= wr_addr_r + 1'b1;
              if ({1'b0, in_col_r} + 1'b1 >= wid) begin
                in_col_r <= '0;
                if ({1'b0, in_row_r} + 1'b1 >= hgt) begin
                  in_row_r     <= '0;
                  frame_rcvd_r <= 1'b1;
                end else begin
                  in_row_r <= in_row_r + 1'b1;
                end
              end else begin
                in_col_r <= in_col_r + 1'b1;
              end
            end
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!win_ready) begin
            state_r <= ST_IDLE;
          end else if (!stat.busy) begin
            job_oy_r    <= out_row_r;
            job_ox_r    <= out_col_r;
            job_obase_r <= obase_r;
            job_r.row   <= gbr_pkg::POS_W'(out_row_r);
            job_r.col   <= gbr_pkg::POS_W'(out_col_r);
            job_r.last  <= is_last;
            ix_r        <= '0;
            iy_r        <= '0;
            // advance the output position
            if (is_last) begin
              in_row_r     <= '0;
              in_col_r     <= '0;
              out_row_r    <= '0;
              out_col_r    <= '0;
              frame_rcvd_r <= 1'b0;
              wr_addr_r    <= '0;
              obase_r      <= '0;
            end else if ({1'b0, out_col_r} + 1'b1 >= wid) begin
              out_col_r <= '0;
              out_row_r <= out_row_r + 1'b1;
              obase_r   <= obase_inc[AW-1:0];
            end else begin
              out_col_r <= out_col_r + 1'b1;
            end
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          // one store read per cycle, columns outer, rows inner
          addr_r          <= s2[AW-1:0];
          tag_r.first_row <= (iy_r == '0);
          tag_r.last_row  <= (iy_r == two_r);
          tag_r.first_col <= (ix_r == '0);
          tag_r.last_all  <= (iy_r == two_r) && (ix_r == two_r);
          tag_r.wy        <= taps[ady[1:0]];
          tag_r.wx        <= taps[adx[1:0]];
          if (iy_r == two_r) begin
            iy_r <= '0;
            ix_r <= ix_r + 1'b1;
            if (ix_r == two_r) state_r <= ST_WAIT;
          end else begin
            iy_r <= iy_r + 1'b1;
          end
        end
        ST_WAIT: begin
          if (stat.done) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `GBR_ASSERT_NEXT(a_accept_to_check, (state_r == ST_IDLE) && in_if.valid, state_r == ST_CHECK)
  `GBR_ASSERT_IMPL(a_start_slot_free, (state_r == ST_RUN) && (ix_r == '0) && (iy_r == '0), !stat.busy)
  `GBR_ASSERT_IMPL(a_wr_addr_range, 1'b1, {1'b0, wr_addr_r} < (AW+1)'(DEPTH))
  `GBR_ASSERT_NEXT(a_run_issues, state_r == ST_RUN, tag_r.valid)
endmodule
`default_nettype wire

/* hdl/gbr_mac.sv */
// Filter datapath: vertical multiply-accumulate per column, then horizontal,
// rounding, saturation and the output register. Depends on gbr_pkg, gbr_out_if.
`default_nettype none
module gbr_mac (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire gbr_pkg::tag_t              tag_in,
  input  wire logic [gbr_pkg::PIX_W-1:0]  rdata,
  input  wire logic                       bypass,
  input  wire gbr_pkg::job_t              job,
  output gbr_pkg::stat_t                  stat,
  gbr_out_if.source                       out_if
);
  gbr_pkg::tag_t                tag_b_r, tag_c_r, tag_d_r, tag_e_r, tag_d_nxt;
  logic [gbr_pkg::PROD_W-1:0]   prod_r;
  logic [gbr_pkg::PIX_W-1:0]    raw_r;
  logic [gbr_pkg::COL_W-1:0]    colsum_r, colsum_nxt, colv_r;
  logic [gbr_pkg::COLP_W-1:0]   colp_r;
  logic [gbr_pkg::ACC_W-1:0]    acc_r, acc_sum;
  logic [gbr_pkg::ACC_W:0]      rnd;
  logic [gbr_pkg::PIX_W-1:0]    pix;
  logic                         out_valid_r;
  logic [gbr_pkg::PIX_W-1:0]    pix_r;
  gbr_pkg::job_t                pos_r;

  assign stat.busy = out_valid_r;
  assign stat.done = tag_e_r.valid && tag_e_r.last_all;

  assign out_if.valid      = out_valid_r;
  assign out_if.pixel_out  = pix_r;
  assign out_if.out_row    = pos_r.row;
  assign out_if.out_col    = pos_r.col;
  assign out_if.frame_last = pos_r.last;

  // column and frame sums, round half up, clip to 0..255; raw pixel when bypassed
  always_comb begin
    tag_d_nxt       = tag_c_r;
    tag_d_nxt.valid = tag_c_r.valid && tag_c_r.last_row;
    colsum_nxt = (tag_c_r.first_row ? '0 : colsum_r) + gbr_pkg::COL_W'(prod_r);
    acc_sum    = (tag_e_r.first_col ? '0 : acc_r) + gbr_pkg::ACC_W'(colp_r);
    rnd        = {1'b0, acc_sum} + ((gbr_pkg::ACC_W+1)'(1) << (gbr_pkg::FRAC_W - 1));
    if (bypass)
      pix = raw_r;
    else if (rnd[gbr_pkg::ACC_W:gbr_pkg::FRAC_W+gbr_pkg::PIX_W] != '0)
      pix = '1;
    else
      pix = rnd[gbr_pkg::FRAC_W+gbr_pkg::PIX_W-1:gbr_pkg::FRAC_W];
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_b_r     <= '0;
      tag_c_r     <= '0;
      tag_d_r     <= '0;
      tag_e_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tag_b_r <= tag_in;
      tag_c_r <= tag_b_r;
      tag_d_r <= tag_d_nxt;
      tag_e_r <= tag_d_r;
      if (stat.done)                  out_valid_r <= 1'b1;
      else if (out_if.ready)          out_valid_r <= 1'b0;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (tag_b_r.valid) begin
      prod_r <= gbr_pkg::PROD_W'(rdata * tag_b_r.wy);
      raw_r  <= rdata;
    end
    if (tag_c_r.valid) colsum_r <= colsum_nxt;
    if (tag_c_r.valid && tag_c_r.last_row) colv_r <= colsum_nxt;
    if (tag_d_r.valid) colp_r <= gbr_pkg::COLP_W'(colv_r * tag_d_r.wx);
    if (tag_e_r.valid) acc_r <= acc_sum;
    if (stat.done) begin
      pix_r <= pix;
      pos_r <= job;
    end
  end
endmodule
`default_nettype wire

/* hdl/gaussian_blur_replicate_border.sv */
// Gaussian blur of an 8-bit raster stream with replicated borders.
// Beats enter on in_if (action 0 pushes pixel_in, action 1 drains one output);
// smoothed pixels leave on out_if with their row, column and a frame_last flag.
// Radius, frame size and the four Q1.16 1-D taps sit behind the cfg_ APB port;
// a write to radius, width or height restarts the frame.
// An input beat is accepted in IDLE, then CHECK tests whether the next
// output's window has fully arrived. If so, the window is read from the line
// store, one pixel per cycle on its single read port, and the result passes
// through the filter pipeline stages into the output register.
// The output register lets the next beat be taken while a result waits; a new
// window is only started once that register has been emptied, so a stalled
// receiver keeps taking beats that bring no result and holds the block at the
// first beat that brings one.
// Reset clears the counters and control registers; the line store is not cleared and
// needs no clearing pass, as only pixels of the current frame are read.
`default_nettype none
module gaussian_blur_replicate_border #(
  parameter int MAX_RADIUS = 3,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  gbr_in_if.sink                          in_if,
  gbr_out_if.source                       out_if,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [gbr_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [gbr_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [gbr_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  localparam int WW    = $clog2(MAX_WIDTH) + 1;
  localparam int HW    = $clog2(MAX_HEIGHT) + 1;
  localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  logic [1:0]                  rad;
  logic [WW-1:0]               wid;
  logic [HW-1:0]               hgt;
  logic [gbr_pkg::TAP_W-1:0]   taps [gbr_pkg::NUM_TAPS];
  logic                        restart;
  gbr_pkg::stat_t              stat;
  gbr_pkg::tag_t               tag;
  gbr_pkg::job_t               job;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [7:0]                  mem_wdata, mem_rdata;

  gbr_cfg #(
    .MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .rad_eff(rad), .wid_eff(wid), .hgt_eff(hgt), .taps(taps), .restart(restart)
  );

  gbr_line_store #(.DEPTH(DEPTH)) u_store (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  gbr_ctrl #(
    .MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)
  ) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_if(in_if),
    .rad(rad), .wid(wid), .hgt(hgt), .taps(taps), .restart(restart), .stat(stat),
    .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr), .tag_r(tag), .job_r(job)
  );

  gbr_mac u_mac (
    .clk(clk), .rst_n(rst_n), .tag_in(tag), .rdata(mem_rdata),
    .bypass(rad == 2'd0), .job(job), .stat(stat), .out_if(out_if)
  );
endmodule
`default_nettype wire

/* tb/tb_gaussian_blur_replicate_border.sv */
// Self-checking testbench of the Gaussian blur block: directed table, then random frames.
// Depends on gbr_pkg, gbr_in_if, gbr_out_if and gaussian_blur_replicate_border.
`default_nettype none
module tb_gaussian_blur_replicate_border;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 7 * 1024;
  localparam int SETTLE      = 64;

  typedef enum bit {ACT_PUSH = 1'b0, ACT_DRAIN = 1'b1} blur_act_e;
  typedef enum bit {ROW_BEAT, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [gbr_pkg::PIX_W-1:0] pix;
    logic [gbr_pkg::POS_W-1:0] row;
    logic [gbr_pkg::POS_W-1:0] col;
    logic                      last;
  } blur_px_t;

  typedef struct {
    row_kind_e                 kind;
    logic [2:0]                idx;
    logic [31:0]               value;
    blur_act_e                 act;
    logic [gbr_pkg::PIX_W-1:0] pix;
    bit                        typed;   // expected result written in the table
    bit                        has_px;
    blur_px_t                  px;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [gbr_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [gbr_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [gbr_pkg::CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  gbr_in_if  in_if();
  gbr_out_if out_if();

  gaussian_blur_replicate_border u_top (
    .clk, .rst_n, .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  always #5 clk = ~clk;

  // shadow of the block: registers, counters, line store
  logic [1:0]  sh_radius;
  logic [10:0] sh_width, sh_height;
  logic [16:0] sh_tap [4];
  int unsigned in_row, in_col, px_row, px_col;
  bit          frame_in;
  byte unsigned line_buf [STORE_DEPTH];

  blur_px_t  pending_px [$];
  stim_row_t stim [$];
  stim_row_t typed_q [$];   // typed rows waiting for their beat to be taken
  int        errors = 0;
  int        idle_mode = 0;  // 0 none, 1 sender, 2 receiver, 3 both light

  function automatic int unsigned eff_w();
    if (sh_width == 0) return 1;
    return (sh_width > 1024) ? 1024 : sh_width;
  endfunction

  function automatic int unsigned eff_h();
    if (sh_height == 0) return 1;
    return (sh_height > 1024) ? 1024 : sh_height;
  endfunction

  function automatic longint unsigned tap_q16(int d);
    return (sh_tap[d] > 17'd65536) ? 64'd65536 : longint'(sh_tap[d]);
  endfunction

  function automatic int unsigned buf_addr(int unsigned r, int unsigned c);
    return (r * eff_w() + c) % STORE_DEPTH;
  endfunction

  function automatic int unsigned clamp_to(int v, int unsigned n);
    if (v < 0) return 0;
    if (v >= int'(n)) return n - 1;
    return v;
  endfunction

  // separable window: vertical sum per column, then horizontal
  function automatic logic [gbr_pkg::PIX_W-1:0] blur_at(int unsigned oy, int unsigned ox);
    longint unsigned acc, colsum, rounded;
    int r;
    r = sh_radius;
    if (r == 0) return line_buf[buf_addr(oy, ox)];
    acc = 0;
    for (int dx = -r; dx <= r; dx++) begin
      colsum = 0;
      for (int dy = -r; dy <= r; dy++)
        colsum += tap_q16(dy < 0 ? -dy : dy) *
                  line_buf[buf_addr(clamp_to(int'(oy) + dy, eff_h()),
                                    clamp_to(int'(ox) + dx, eff_w()))];
      acc += tap_q16(dx < 0 ? -dx : dx) * colsum;
    end
    rounded = (acc + (64'd1 << 31)) >> 32;
    return (rounded > 255) ? 8'd255 : rounded[7:0];
  endfunction

  function automatic void restart_frame();
    in_row = 0; in_col = 0; px_row = 0; px_col = 0; frame_in = 0;
  endfunction

  function automatic void shadow_cfg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      gbr_pkg::REG_RADIUS: begin sh_radius = v[1:0]; restart_frame(); end
      gbr_pkg::REG_WIDTH:  begin sh_width = v[10:0]; restart_frame(); end
      gbr_pkg::REG_HEIGHT: begin sh_height = v[10:0]; restart_frame(); end
      gbr_pkg::REG_TAP0:   sh_tap[0] = v[16:0];
      gbr_pkg::REG_TAP1:   sh_tap[1] = v[16:0];
      gbr_pkg::REG_TAP2:   sh_tap[2] = v[16:0];
      gbr_pkg::REG_TAP3:   sh_tap[3] = v[16:0];
      default: ;
    endcase
  endfunction

  // one beat through the shadow; returns 1 when a pixel comes out
  function automatic bit blur_step(blur_act_e act, logic [gbr_pkg::PIX_W-1:0] pix,
                                   output blur_px_t px);
    int unsigned w, h, nr, nc;
    bit ready;
    w = eff_w(); h = eff_h();
    px = '0;
    if (act == ACT_PUSH && !frame_in) begin
      line_buf[buf_addr(in_row, in_col)] = pix;
      if (++in_col >= w) begin
        in_col = 0;
        if (++in_row >= h) begin in_row = 0; frame_in = 1; end
      end
    end
    if (frame_in) ready = 1;
    else begin
      nr = (px_row + sh_radius > h - 1) ? h - 1 : px_row + sh_radius;
      nc = (px_col + sh_radius > w - 1) ? w - 1 : px_col + sh_radius;
      ready = (nr < in_row) || (nr == in_row && nc < in_col);
    end
    if (!ready) return 0;
    px.pix  = blur_at(px_row, px_col);
    px.row  = px_row[gbr_pkg::POS_W-1:0];
    px.col  = px_col[gbr_pkg::POS_W-1:0];
    px.last = (px_row == h - 1) && (px_col == w - 1);
    if (px.last) restart_frame();
    else if (++px_col >= w) begin px_col = 0; px_row++; end
    return 1;
  endfunction

  // accepted input beat: predict
  always @(posedge clk) begin
    blur_px_t px;
    stim_row_t tr;
    bit got;
    if (rst_n && in_if.valid && in_if.ready) begin
      got = blur_step(blur_act_e'(in_if.action), in_if.pixel_in, px);
      if (typed_q.size() != 0) begin
        tr = typed_q.pop_front();
        if (tr.has_px) pending_px.push_back(tr.px);
        if (got != tr.has_px) begin
          $display("%0t: table row disagrees with prediction: has %0b vs %0b",
                   $time, tr.has_px, got);
          errors++;
        end
      end else if (got) pending_px.push_back(px);
    end
  end

  // accepted result beat: check
  always @(posedge clk) begin
    blur_px_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_px.size() == 0) begin
        $display("%0t: expected no pixel, actual pixel %0d at (%0d,%0d)", $time,
                 out_if.pixel_out, out_if.out_row, out_if.out_col);
        errors++;
      end else begin
        want = pending_px.pop_front();
        if (out_if.pixel_out !== want.pix || out_if.out_row !== want.row ||
            out_if.out_col !== want.col || out_if.frame_last !== want.last) begin
          $display("%0t: mismatch expected pix %0d row %0d col %0d last %0b",
                   $time, want.pix, want.row, want.col, want.last);
          $display("%0t:          actual   pix %0d row %0d col %0d last %0b",
                   $time, out_if.pixel_out, out_if.out_row, out_if.out_col,
                   out_if.frame_last);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    int pct;
    pct = (idle_mode == 2) ? 51 : (idle_mode == 3) ? 8 : 0;
    out_if.ready <= ($urandom_range(0, 99) >= pct);
  end

  task automatic drive_beat(blur_act_e act, logic [gbr_pkg::PIX_W-1:0] pix);
    int pct;
    pct = (idle_mode == 1) ? 51 : (idle_mode == 3) ? 8 : 0;
    if ($urandom_range(0, 99) < pct) begin
      in_if.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < pct);
    end
    in_if.valid    <= 1'b1;
    in_if.action   <= act;
    in_if.pixel_in <= pix;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // idle block, then one APB write
  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (pending_px.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= gbr_pkg::CFG_AW'({idx, 2'b00}); cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    shadow_cfg(idx, v);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  function automatic void add_cfg(logic [2:0] idx, logic [31:0] v);
    stim_row_t s;
    s = '{kind: ROW_CFG, act: ACT_PUSH, default: '0};
    s.idx = idx; s.value = v;
    stim.push_back(s);
  endfunction

  function automatic void add_beat(blur_act_e act, logic [gbr_pkg::PIX_W-1:0] pix,
                                   bit typed = 0, bit has_px = 0, blur_px_t px = '0);
    stim_row_t s;
    s = '{kind: ROW_BEAT, act: ACT_PUSH, default: '0};
    s.act = act; s.pix = pix;
    s.typed = typed; s.has_px = has_px; s.px = px;
    stim.push_back(s);
  endfunction

  function automatic bit frame_open();
    return frame_in || px_row != 0 || px_col != 0;
  endfunction

  initial begin
    int items, ew, eh, pick;
    bit wide;
    in_if.valid = 1'b0; in_if.action = ACT_PUSH; in_if.pixel_in = '0;
    out_if.ready = 1'b0;
    sh_radius = 0; sh_width = 11'd1024; sh_height = 11'd1024;
    sh_tap[0] = 17'd65536; sh_tap[1] = 0; sh_tap[2] = 0; sh_tap[3] = 0;
    restart_frame();
    foreach (line_buf[i]) line_buf[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: pass-through 3x2 frame
    add_cfg(gbr_pkg::REG_WIDTH, 3); add_cfg(gbr_pkg::REG_HEIGHT, 2);
    add_beat(ACT_PUSH, 8'd0,   1, 1, '{8'd0,   10'd0, 10'd0, 1'b0});
    add_beat(ACT_PUSH, 8'd255, 1, 1, '{8'd255, 10'd0, 10'd1, 1'b0});
    add_beat(ACT_PUSH, 8'h55,  1, 1, '{8'h55,  10'd0, 10'd2, 1'b0});
    add_beat(ACT_PUSH, 8'hAA,  1, 1, '{8'hAA,  10'd1, 10'd0, 1'b0});
    add_beat(ACT_PUSH, 8'd1,   1, 1, '{8'd1,   10'd1, 10'd1, 1'b0});
    add_beat(ACT_PUSH, 8'd128, 1, 1, '{8'd128, 10'd1, 10'd2, 1'b1});
    add_beat(ACT_DRAIN, 8'd0,  1, 0);
    // zero width and height fall back to a single pixel
    add_cfg(gbr_pkg::REG_WIDTH, 0); add_cfg(gbr_pkg::REG_HEIGHT, 0);
    add_beat(ACT_PUSH, 8'd77,  1, 1, '{8'd77, 10'd0, 10'd0, 1'b1});
    // oversized taps saturate to one, a window of mostly white saturates
    add_cfg(gbr_pkg::REG_RADIUS, 3); add_cfg(gbr_pkg::REG_WIDTH, 4);
    add_cfg(gbr_pkg::REG_HEIGHT, 3);
    add_cfg(gbr_pkg::REG_TAP0, 32'h1FFFF); add_cfg(gbr_pkg::REG_TAP1, 32'h1FFFF);
    add_cfg(gbr_pkg::REG_TAP2, 32'h1FFFF); add_cfg(gbr_pkg::REG_TAP3, 32'h1FFFF);
    for (int i = 0; i < 12; i++) add_beat(ACT_PUSH, (i == 5) ? 8'd0 : 8'd255);
    add_beat(ACT_PUSH, 8'd9);  // frame complete: acts as a drain
    for (int i = 0; i < 12; i++) add_beat(ACT_DRAIN, 8'd0);
    // round half up: half weight in each direction on a value of 2
    add_cfg(gbr_pkg::REG_RADIUS, 1); add_cfg(gbr_pkg::REG_WIDTH, 2);
    add_cfg(gbr_pkg::REG_HEIGHT, 1);
    add_cfg(gbr_pkg::REG_TAP0, 32768); add_cfg(gbr_pkg::REG_TAP1, 0);
    add_cfg(gbr_pkg::REG_TAP2, 0); add_cfg(gbr_pkg::REG_TAP3, 0);
    add_beat(ACT_PUSH, 8'd2); add_beat(ACT_PUSH, 8'd6);
    add_beat(ACT_DRAIN, 8'd0); add_beat(ACT_DRAIN, 8'd0);

    foreach (stim[i]) begin
      if (stim[i].kind == ROW_CFG) write_reg(stim[i].idx, stim[i].value);
      else begin
        if (stim[i].typed) typed_q.push_back(stim[i]);
        drive_beat(stim[i].act, stim[i].pix);
      end
    end

    // random frames, one geometry and tap set per phase
    items = 0;
    for (int ph = 0; items < 850; ph++) begin
      write_reg(gbr_pkg::REG_RADIUS, $urandom_range(0, 3));
      pick = $urandom_range(0, 19);
      wide = (pick == 0);
      write_reg(gbr_pkg::REG_WIDTH, wide ? (($urandom_range(0, 1) != 0) ? 1024 : 2047)
                         : (pick == 1) ? 0 : $urandom_range(1, 9));
      write_reg(gbr_pkg::REG_HEIGHT, wide ? $urandom_range(0, 1)
                          : (pick == 2) ? 2047 : $urandom_range(0, 5));
      for (int t = 0; t < 4; t++)
        write_reg(3'(gbr_pkg::REG_TAP0 + t),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17'h1FFFF)
                                              : $urandom_range(0, 40000 >> t));
      idle_mode = ph % 4;
      ew = eff_w(); eh = eff_h();
      if (wide || eh > 64) begin
        // huge frame: a stretch of pushes, cut short by the next geometry write
        for (int k = 0; k < 60; k++) begin
          drive_beat(($urandom_range(0, 9) == 0) ? ACT_DRAIN : ACT_PUSH,
                     8'($urandom_range(0, 255)));
          items++;
        end
      end else begin
        for (int f = $urandom_range(1, 2); f > 0; f--) begin
          for (int k = 0; k < ew * eh; k++) begin
            if ($urandom_range(0, 9) == 0) begin
              drive_beat(ACT_DRAIN, 8'($urandom_range(0, 255)));
              items++;
            end
            drive_beat(ACT_PUSH, 8'($urandom_range(0, 255)));
            items++;
          end
          while (frame_open()) begin
            drive_beat(($urandom_range(0, 99) < 15) ? ACT_PUSH : ACT_DRAIN,
                       8'($urandom_range(0, 255)));
            items++;
          end
        end
      end
    end

    in_if.valid <= 1'b0;
    while (pending_px.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // hang guard
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
